@@ rtl/core/hilbert_scan_address_generator_core_macros.svh @@
// Assertion macros shared by the checker of the Hilbert scan address generator.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef HILBERT_SCAN_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define HILBERT_SCAN_ADDRESS_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define HSAG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsag assertion failed");

// Next-cycle implication, ignored while reset is high.
`define HSAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsag assertion failed");

// Next-cycle implication that is checked during reset as well.
`define HSAG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hsag assertion failed");

`endif

@@ rtl/core/hsag_pkg.sv @@
// Package of the Hilbert scan address generator: field widths, curve order and types.
// Depends on nothing; used by the interfaces, the decoder and the top level.
package hsag_pkg;

   localparam int LEVELS   = 5;
   localparam int COORD_W  = LEVELS;
   localparam int POS_W    = 2 * LEVELS;
   localparam int SIDE_W   = 6;
   localparam int RASTER_W = 10;
   localparam int PROD_W   = 2 * SIDE_W;

   localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = SIDE_W'(32);

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
   } hsag_cell_type;

   typedef struct packed {
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  column;
      logic [RASTER_W-1:0] raster_index;
      logic                keep;
   } hsag_result_type;

endpackage

@@ rtl/core/hsag_if.sv @@
// Channel interfaces of the Hilbert scan address generator: request, response, register write.
// Depends on hsag_pkg for the payload widths.
interface hsag_req_if;
   logic                      valid;
   logic                      ready;
   logic [hsag_pkg::POS_W-1:0] curve_position;

   modport source (output valid, output curve_position, input ready);
   modport sink (input valid, input curve_position, output ready);
endinterface

interface hsag_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hsag_pkg::COORD_W-1:0]  row;
   logic [hsag_pkg::COORD_W-1:0]  column;
   logic [hsag_pkg::RASTER_W-1:0] raster_index;
   logic                         keep;

   modport source (output valid, output row, output column, output raster_index,
                   output keep, input ready);
   modport sink (input valid, input row, input column, input raster_index,
                 input keep, output ready);
endinterface

interface hsag_csr_if;
   logic                       valid;
   logic                       ready;
   logic [hsag_pkg::SIDE_W-1:0] grid_side;

   modport source (output valid, output grid_side, input ready);
   modport sink (input valid, input grid_side, output ready);
endinterface

@@ rtl/core/hsag_curve_decode.sv @@
// Hilbert curve decoder: maps a curve position to its grid cell, one bit pair per level.
// Depends on hsag_pkg.
module hsag_curve_decode (
   input  logic [hsag_pkg::POS_W-1:0] position,
   output hsag_pkg::hsag_cell_type    grid_point
);
   import hsag_pkg::*;

   logic [COORD_W-1:0] a;
   logic [COORD_W-1:0] b;
   logic [COORD_W-1:0] swap;
   logic [COORD_W-1:0] low_mask;
   logic [COORD_W-1:0] bit_mask;
   logic [POS_W-1:0]   t;
   logic               ra;
   logic               rb;

   // Pairs are taken from the least significant end; at each level the sub-quadrant
   // coordinates are swapped, and reflected, as the quadrant requires, before the quadrant bit is added.
   always_comb begin
      a = '0;
      b = '0;
      t = position;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         ra       = t[1];
         rb       = t[0] ^ t[1];
         bit_mask = COORD_W'(1) << lvl;
         low_mask = bit_mask - COORD_W'(1);
         if (!rb) begin
            if (ra) begin
               a = a ^ low_mask;
               b = b ^ low_mask;
            end
            swap = a;
            a    = b;
            b    = swap;
         end else begin
            swap = a;
         end
         if (ra) begin
            a = a | bit_mask;
         end
         if (rb) begin
            b = b | bit_mask;
         end
         t = t >> 2;
      end
      grid_point.row    = b;
      grid_point.column = a;
   end

endmodule

@@ rtl/core/hilbert_scan_address_generator_core.sv @@
// Hilbert scan address generator, top level.
// Channels: req_bus carries a curve position, rsp_bus returns row, column,
// raster index and keep flag, csr_bus writes the grid_side register.
// Each accepted request gives exactly one response, in order.
// A request passes an input register, then decode and raster arithmetic into the
// result register. Throughput is one transaction per cycle while the receiver
// does not stall.
// The raster multiply of a 5-bit row by the 6-bit grid_side sits in the
// second stage next to the curve decoder and sets its path.
// Only the low ten bits of curve_position are used.
// Reset empties both stages and sets grid_side to 32.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more; after that req_bus.ready drops.
// The csr_bus is always ready; write it only while the block is idle.
module hilbert_scan_address_generator_core (
   input  logic       clock,
   input  logic       reset,
   hsag_req_if.sink   req_bus,
   hsag_rsp_if.source rsp_bus,
   hsag_csr_if.sink   csr_bus
);
   import hsag_pkg::*;

   logic [SIDE_W-1:0] grid_side_ff;
   logic [SIDE_W-1:0] grid_side_in;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [POS_W-1:0]  position_ff;
   logic [POS_W-1:0]  position_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   hsag_result_type   result_ff;
   hsag_result_type   result_in;

   hsag_cell_type     grid_point;
   logic              out_ready;
   logic              in_ready;
   logic              keep;
   logic [PROD_W-1:0] raster_sum;

   hsag_curve_decode u_decode (
      .position   (position_ff),
      .grid_point (grid_point)
   );

   assign out_ready = !out_valid_ff || rsp_bus.ready;
   assign in_ready  = !in_valid_ff || out_ready;

   assign keep = ({1'b0, grid_point.row} < grid_side_ff) &&
                 ({1'b0, grid_point.column} < grid_side_ff);
   assign raster_sum = PROD_W'(grid_point.row) * PROD_W'(grid_side_ff) +
                       PROD_W'(grid_point.column);

   always_comb begin
      grid_side_in = grid_side_ff;
      if (csr_bus.valid) begin
         grid_side_in = csr_bus.grid_side;
      end

      in_valid_in = in_valid_ff;
      position_in = position_ff;
      if (in_ready) begin
         in_valid_in = req_bus.valid;
         position_in = req_bus.curve_position;
      end

      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (out_ready) begin
         out_valid_in           = in_valid_ff;
         result_in.row          = grid_point.row;
         result_in.column       = grid_point.column;
         result_in.keep         = keep;
         result_in.raster_index = keep ? raster_sum[RASTER_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         grid_side_ff <= grid_side_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      position_ff <= position_in;
      result_ff   <= result_in;
   end

   assign req_bus.ready        = in_ready;
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.row          = result_ff.row;
   assign rsp_bus.column       = result_ff.column;
   assign rsp_bus.raster_index = result_ff.raster_index;
   assign rsp_bus.keep         = result_ff.keep;

endmodule

@@ rtl/core/hsag_checker.sv @@
// Port-level checker of the Hilbert scan address generator, bound to the top level.
// Depends on hsag_pkg and the assertion macro header.
`include "hilbert_scan_address_generator_core_macros.svh"

module hsag_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hsag_pkg::COORD_W-1:0]  rsp_row,
   input logic [hsag_pkg::COORD_W-1:0]  rsp_column,
   input logic [hsag_pkg::RASTER_W-1:0] rsp_raster_index,
   input logic                          rsp_keep
);
   import hsag_pkg::*;

   logic [2*COORD_W+RASTER_W:0] rsp_payload;

   assign rsp_payload = {rsp_row, rsp_column, rsp_raster_index, rsp_keep};

   `HSAG_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)

   `HSAG_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   `HSAG_ASSERT_SAME(a_dropped_cell_zero, clock, reset, rsp_valid && !rsp_keep, rsp_raster_index == '0)

   `HSAG_ASSERT_NEXT(a_empty_accepts, clock, reset, !rsp_valid && !(req_valid && req_ready), req_ready)

endmodule

bind hilbert_scan_address_generator_core hsag_checker u_hsag_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_row          (rsp_bus.row),
   .rsp_column       (rsp_bus.column),
   .rsp_raster_index (rsp_bus.raster_index),
   .rsp_keep         (rsp_bus.keep)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the Hilbert scan address generator core.
// Drives curve positions and grid_side writes and checks every response against table values or a predictor.
// Depends on hsag_pkg, the channel interfaces in hsag_if.sv and the core top level.
module tb;
   import hsag_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 125;
   localparam int PHASE_COUNT   = 6;
   localparam int STALL_AT      = 300;
   localparam int STALL_CYCLES  = 60;
   localparam int CALM_FIRST    = 450;
   localparam int CALM_LAST     = 550;
   localparam int IDLE_PERCENT  = 29;
   localparam int PRINT_LIMIT   = 50;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [POS_W-1:0]  pos;
      logic              typed;
      hsag_result_type   want_out;
   } scan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsag_req_if req_bus ();
   hsag_rsp_if rsp_bus ();
   hsag_csr_if csr_bus ();

   hilbert_scan_address_generator_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   hsag_result_type   pending_cells[$];
   logic [SIDE_W-1:0] grid_side_model = GRID_SIDE_RESET;
   int                mismatch_count  = 0;
   int                n_accepted      = 0;
   int                cycle_count     = 0;
   int                stall_left      = 0;
   bit                stall_done      = 1'b0;

   wire calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);

   scan_row_type scan_table [24] = '{
      '{6'd32, 10'd0,    1'b1, '{5'd0,  5'd0,  10'd0,  1'b1}},
      '{6'd32, 10'd1,    1'b1, '{5'd1,  5'd0,  10'd32, 1'b1}},
      '{6'd32, 10'd2,    1'b1, '{5'd1,  5'd1,  10'd33, 1'b1}},
      '{6'd32, 10'd3,    1'b1, '{5'd0,  5'd1,  10'd1,  1'b1}},
      '{6'd32, 10'd1023, 1'b1, '{5'd0,  5'd31, 10'd31, 1'b1}},
      '{6'd32, 10'd512,  1'b0, '0},
      '{6'd32, 10'd341,  1'b0, '0},
      '{6'd32, 10'd682,  1'b0, '0},
      '{6'd0,  10'd0,    1'b1, '{5'd0,  5'd0,  10'd0,  1'b0}},
      '{6'd0,  10'd1023, 1'b1, '{5'd0,  5'd31, 10'd0,  1'b0}},
      '{6'd0,  10'd2,    1'b1, '{5'd1,  5'd1,  10'd0,  1'b0}},
      '{6'd1,  10'd0,    1'b1, '{5'd0,  5'd0,  10'd0,  1'b1}},
      '{6'd1,  10'd1,    1'b1, '{5'd1,  5'd0,  10'd0,  1'b0}},
      '{6'd1,  10'd3,    1'b1, '{5'd0,  5'd1,  10'd0,  1'b0}},
      '{6'd1,  10'd600,  1'b0, '0},
      '{6'd63, 10'd1,    1'b1, '{5'd1,  5'd0,  10'd63, 1'b1}},
      '{6'd63, 10'd2,    1'b1, '{5'd1,  5'd1,  10'd64, 1'b1}},
      '{6'd63, 10'd1023, 1'b1, '{5'd0,  5'd31, 10'd31, 1'b1}},
      '{6'd63, 10'd700,  1'b0, '0},
      '{6'd63, 10'd511,  1'b0, '0},
      '{6'd33, 10'd1023, 1'b1, '{5'd0,  5'd31, 10'd31, 1'b1}},
      '{6'd33, 10'd555,  1'b0, '0},
      '{6'd31, 10'd1023, 1'b1, '{5'd0,  5'd31, 10'd0,  1'b0}},
      '{6'd31, 10'd1,    1'b1, '{5'd1,  5'd0,  10'd31, 1'b1}}
   };

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic hsag_result_type decode_curve_cell(input logic [POS_W-1:0] pos,
                                                         input logic [SIDE_W-1:0] side);
      logic [COORD_W-1:0] col_acc;
      logic [COORD_W-1:0] row_acc;
      logic [COORD_W-1:0] swap_tmp;
      logic [COORD_W-1:0] span;
      logic [POS_W-1:0]   digits;
      logic               quad_hi;
      logic               quad_lo;
      logic [PROD_W-1:0]  product;
      hsag_result_type    result;
      col_acc = '0;
      row_acc = '0;
      digits  = pos;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         span    = COORD_W'(1 << lvl);
         quad_hi = digits[1];
         quad_lo = digits[0] ^ quad_hi;
         if (!quad_lo) begin
            if (quad_hi) begin
               col_acc = span - 1'b1 - col_acc;
               row_acc = span - 1'b1 - row_acc;
            end
            swap_tmp = col_acc;
            col_acc  = row_acc;
            row_acc  = swap_tmp;
         end
         if (quad_hi) col_acc = col_acc + span;
         if (quad_lo) row_acc = row_acc + span;
         digits = digits >> 2;
      end
      result.row    = row_acc;
      result.column = col_acc;
      result.keep   = ({1'b0, row_acc} < side) && ({1'b0, col_acc} < side);
      product       = PROD_W'(row_acc) * PROD_W'(side) + PROD_W'(col_acc);
      result.raster_index = result.keep ? product[RASTER_W-1:0] : '0;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic offer_position(input logic [POS_W-1:0] pos, input logic typed,
                                 input hsag_result_type typed_out);
      hsag_result_type want_out;
      @(negedge clock);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while (!calm && $urandom_range(99) < IDLE_PERCENT);
      end
      req_bus.valid          <= 1'b1;
      req_bus.curve_position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      want_out      = typed ? typed_out : decode_curve_cell(pos, grid_side_model);
      pending_cells = {pending_cells, want_out};
      n_accepted++;
   endtask

   task automatic write_grid_side(input logic [SIDE_W-1:0] side);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.grid_side <= side;
      do @(posedge clock); while (!csr_bus.ready);
      grid_side_model = side;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.curve_position = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.grid_side      = '0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!stall_done && n_accepted >= STALL_AT) begin
         rsp_bus.ready <= 1'b0;
         stall_left = STALL_CYCLES - 1;
         stall_done = 1'b1;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      hsag_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_cells.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            want = pending_cells.pop_front();
            if (rsp_bus.row !== want.row)
               report_mismatch($sformatf("row %0d, expected %0d", rsp_bus.row, want.row));
            if (rsp_bus.column !== want.column)
               report_mismatch($sformatf("column %0d, expected %0d",
                                         rsp_bus.column, want.column));
            if (rsp_bus.raster_index !== want.raster_index)
               report_mismatch($sformatf("raster_index %0d, expected %0d",
                                         rsp_bus.raster_index, want.raster_index));
            if (rsp_bus.keep !== want.keep)
               report_mismatch($sformatf("keep %0b, expected %0b", rsp_bus.keep, want.keep));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [SIDE_W-1:0] phase_side;
      logic [POS_W-1:0]  pos;
      logic [POS_W-1:0]  walk_pos;
      int                walk_left;
      walk_left = 0;
      walk_pos  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (scan_table[i]) begin
         if (scan_table[i].side != grid_side_model) write_grid_side(scan_table[i].side);
         offer_position(scan_table[i].pos, scan_table[i].typed, scan_table[i].want_out);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_side = 6'd32;
            1: phase_side = SIDE_W'($urandom_range(1, 32));
            2: phase_side = 6'd63;
            3: phase_side = SIDE_W'($urandom_range(0, 63));
            4: phase_side = 6'd1;
            default: phase_side = SIDE_W'($urandom_range(2, 31));
         endcase
         write_grid_side(phase_side);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (walk_left == 0 && $urandom_range(99) < 30) begin
               walk_left = $urandom_range(4, 24);
               walk_pos  = POS_W'($urandom);
            end
            if (walk_left != 0) begin
               pos = walk_pos;
               walk_pos++;
               walk_left--;
            end else begin
               pos = POS_W'($urandom);
            end
            offer_position(pos, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (pending_cells.size() != 0)
         report_mismatch("requests left without a response");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hsag_pkg.sv
rtl/core/hsag_if.sv
rtl/core/hsag_curve_decode.sv
rtl/core/hilbert_scan_address_generator_core.sv
rtl/core/hsag_checker.sv
tb/tb.sv
